// File: design/sawlc_pkg.sv
// Shared types, constants and helpers for the set-associative write-back cache.
package sawlc_pkg;

  localparam int MAX_LINES       = 64;
  localparam int MAX_BLOCK_WORDS = 16;
  localparam int MAX_WAYS        = 8;
  localparam int ADDR_BITS       = 16;
  localparam int RANK_LIMIT      = 8;

  localparam int LINE_W  = $clog2(MAX_LINES);
  localparam int WAY_W   = $clog2(MAX_WAYS);
  localparam int WORDS_D = MAX_LINES * MAX_BLOCK_WORDS;
  localparam int WORDS_W = $clog2(WORDS_D);
  localparam int CNT_W   = $clog2(MAX_BLOCK_WORDS) + 1;
  localparam int BK_D    = 1 << ADDR_BITS;
  localparam int META_W  = ADDR_BITS + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_STORE = 3'd1;
  localparam logic [2:0] KIND_FILL  = 3'd2;
  localparam logic [2:0] KIND_WBACK = 3'd3;
  localparam logic [2:0] KIND_DROP  = 3'd4;

  typedef struct packed {
    logic [15:0]        word_address;
    logic               is_write;
    logic signed [31:0] store_word;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         transfer_kind;
    logic [15:0]        start_address;
    logic [4:0]         word_count;
    logic signed [31:0] load_word;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic       clr_step;
    logic       start;
    logic       cnt_clr;
    logic       scan;
    logic       evict;
    logic       fill;
    logic       touch;
    logic       proc;
    logic       capture;
    logic       emit;
    logic [2:0] kind;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic way_done;
    logic blk_done;
    logic hit;
    logic vic_valid;
    logic vic_dirty;
    logic is_write;
    logic out_free;
  } dp_status_t;

  function automatic logic geometry_ok(input logic [2:0] bb, input logic [2:0] sb,
                                       input logic [3:0] w);
    logic [11:0] lines;
    lines = 12'((9'd1 << sb) * w);
    return (bb <= 3'($clog2(MAX_BLOCK_WORDS))) && (w != 4'd0) &&
           (int'(w) <= MAX_WAYS) && (int'(w) <= RANK_LIMIT) &&
           (int'(lines) <= MAX_LINES) && (int'(bb) + int'(sb) <= ADDR_BITS);
  endfunction

endpackage

// File: design/set_assoc_writeback_lru_cache.sv
// Top level of the set-associative write-back write-allocate LRU cache.
// Each accepted word is one access to a cache with true LRU replacement in front of a 64K-word
// backing memory; it produces one to three transfer records in order (eviction of a valid victim,
// block fill, processor transfer), the last of which carries the read data of a read. After reset
// the backing memory is swept to zero, one word a cycle, during which no access word is taken;
// configuration writes are accepted throughout. The block works on one access at a time; a load
// passes through a wait state for the registered read of the word store, which a store skips.
// Each access runs a one-way-per-cycle tag and rank scan and a one-way-per-cycle LRU update
// through metadata memories that have one read and one write port each. A miss adds the fill
// and its record, a write-back when the victim is dirty, or a record alone for a clean valid
// victim; the block moves through the word store one word a cycle. Each record waits while the
// output is stalled. A new access is taken while the final record still waits in the output
// register. Geometry writes that fail the checks (block or index bits too wide, zero or too many
// ways, more lines than the capacity) are ignored; an accepted one invalidates every line and
// discards dirty data.
module set_assoc_writeback_lru_cache
  import sawlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // The controller sequences each access; the datapath holds all storage.
  sawlc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .st(st), .cmd(cmd)
  );

  sawlc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .st(st),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

endmodule

// File: design/sawlc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sawlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sawlc_ctrl.sv
// Controller state machine sequencing lookup, eviction, fill, LRU update and reply.
module sawlc_ctrl
  import sawlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_EVICT, S_EMIT_EV, S_FILL, S_EMIT_FILL,
    S_TOUCH, S_PROC, S_PWAIT, S_EMIT_LAST
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.way_done) begin
          cmd.cnt_clr = 1'b1;
          if (st.hit) state_nxt = S_TOUCH;
          else if (st.vic_valid && st.vic_dirty) state_nxt = S_EVICT;
          else if (st.vic_valid) state_nxt = S_EMIT_EV;
          else state_nxt = S_FILL;
        end
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        if (st.blk_done) state_nxt = S_EMIT_EV;
      end
      S_EMIT_EV: begin
        cmd.kind = st.vic_dirty ? KIND_WBACK : KIND_DROP;
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (st.blk_done) state_nxt = S_EMIT_FILL;
      end
      S_EMIT_FILL: begin
        cmd.kind = KIND_FILL;
        if (st.out_free) begin
          cmd.emit    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_TOUCH;
        end
      end
      S_TOUCH: begin
        cmd.touch = 1'b1;
        if (st.way_done) state_nxt = S_PROC;
      end
      S_PROC: begin
        cmd.proc  = 1'b1;
        state_nxt = st.is_write ? S_EMIT_LAST : S_PWAIT;
      end
      S_PWAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = S_EMIT_LAST;
      end
      S_EMIT_LAST: begin
        cmd.kind = st.is_write ? KIND_STORE : KIND_LOAD;
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/sawlc_dp.sv
// Datapath: geometry registers, line metadata, word stores, backing memory and output register.
module sawlc_dp
  import sawlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_word_t              in_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_status_t            st,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word
);

  // Geometry
  logic [2:0] bb_r, sb_r;
  logic [3:0] ways_r;

  // Current access
  logic [15:0]        addr_r, tag_r;
  logic               wr_r;
  logic signed [31:0] data_r;
  logic [LINE_W-1:0]  base_r;
  logic [LINE_W-1:0]  set_r;

  // Sequencing
  logic [CNT_W-1:0]   cnt_r, pidx_r;
  logic               pend_r;
  logic [ADDR_BITS:0] clr_r;

  // Lookup results
  logic              hit_r, hit_dirty_r, vic_valid_r, vic_dirty_r;
  logic [WAY_W-1:0]  hway_r, bway_r;
  logic [2:0]        hrank_r, best_r;
  logic              best_set_r;
  logic [15:0]       vic_tag_r;
  logic [2:0]        rank_q_r [MAX_WAYS];
  logic signed [31:0] ld_r;

  logic [MAX_LINES-1:0] vld_r, rkv_r;

  out_word_t out_r;
  logic      out_valid_r;

  // Derived values
  logic [15:0]        blk_mask, block_base, vaddr;
  logic [4:0]         bw;
  logic [WAY_W-1:0]   lway;
  logic [LINE_W-1:0]  ln, scan_idx, pidx_line, touch_line;
  logic [WORDS_W-1:0] ln_base;
  logic [2:0]         lrank, pr_rank, cur_rank, new_rank;
  logic               p_valid;

  // RAM ports
  logic               meta_we, rank_we, lw_we, bk_we;
  logic [LINE_W-1:0]  meta_raddr, rank_waddr;
  logic [META_W-1:0]  meta_wdata, meta_rdata;
  logic [2:0]         rank_rdata;
  logic [WORDS_W-1:0] lw_waddr, lw_raddr;
  logic [31:0]        lw_wdata, lw_rdata, bk_rdata, bk_wdata;
  logic [ADDR_BITS-1:0] bk_addr;

  logic [2:0] in_bb_dummy;
  logic [15:0] in_set_w;

  assign bw         = 5'd1 << bb_r;
  assign blk_mask   = (16'd1 << bb_r) - 16'd1;
  assign block_base = addr_r & ~blk_mask;
  assign vaddr      = (vic_tag_r << (4'(bb_r) + 4'(sb_r))) | (16'(set_r) << bb_r);
  assign lway       = hit_r ? hway_r : bway_r;
  assign lrank      = hit_r ? hrank_r : best_r;
  assign ln         = LINE_W'(base_r + LINE_W'(lway));
  assign ln_base    = WORDS_W'(WORDS_W'(ln) << bb_r);
  assign scan_idx   = LINE_W'(base_r + LINE_W'(cnt_r));
  assign pidx_line  = LINE_W'(base_r + LINE_W'(pidx_r));
  assign touch_line = scan_idx;
  assign p_valid    = vld_r[pidx_line];
  assign pr_rank    = rkv_r[pidx_line] ? rank_rdata : 3'(pidx_r);
  assign cur_rank   = rank_q_r[WAY_W'(cnt_r)];
  assign new_rank   = (WAY_W'(cnt_r) == lway) ? 3'(ways_r - 4'd1) :
                      (cur_rank > lrank) ? (cur_rank - 3'd1) : cur_rank;
  assign in_bb_dummy = bb_r;
  assign in_set_w    = (in_word.word_address >> in_bb_dummy) &
                       ((16'd1 << sb_r) - 16'd1);

  // Memory port steering
  always_comb begin
    meta_raddr = scan_idx;
    meta_we    = cmd.touch && (cnt_r == '0);
    meta_wdata = {wr_r | (hit_r & hit_dirty_r), tag_r};
    rank_we    = cmd.touch && (cnt_r < CNT_W'(ways_r));
    rank_waddr = touch_line;
    lw_we      = 1'b0;
    lw_waddr   = WORDS_W'(ln_base + WORDS_W'(pidx_r));
    lw_wdata   = bk_rdata;
    lw_raddr   = WORDS_W'(ln_base + WORDS_W'(cnt_r));
    bk_we      = 1'b0;
    bk_addr    = ADDR_BITS'(block_base + 16'(cnt_r));
    bk_wdata   = lw_rdata;
    if (cmd.clr_step) begin
      bk_we    = !clr_r[ADDR_BITS];
      bk_addr  = clr_r[ADDR_BITS-1:0];
      bk_wdata = 32'd0;
    end else if (cmd.evict) begin
      bk_we   = pend_r;
      bk_addr = ADDR_BITS'(vaddr + 16'(pidx_r));
    end else if (cmd.fill) begin
      lw_we = pend_r;
    end else if (cmd.proc) begin
      lw_raddr = WORDS_W'(ln_base + WORDS_W'(addr_r & blk_mask));
      lw_we    = wr_r;
      lw_waddr = lw_raddr;
      lw_wdata = data_r;
    end
  end

  sawlc_ram #(.WIDTH(META_W), .DEPTH(MAX_LINES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(ln), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  sawlc_ram #(.WIDTH(3), .DEPTH(MAX_LINES)) u_rank (
    .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(new_rank),
    .raddr(scan_idx), .rdata(rank_rdata)
  );

  sawlc_ram #(.WIDTH(32), .DEPTH(WORDS_D)) u_words (
    .clk(clk), .we(lw_we), .waddr(lw_waddr), .wdata(lw_wdata),
    .raddr(lw_raddr), .rdata(lw_rdata)
  );

  sawlc_ram #(.WIDTH(32), .DEPTH(BK_D)) u_backing (
    .clk(clk), .we(bk_we), .waddr(bk_addr), .wdata(bk_wdata),
    .raddr(bk_addr), .rdata(bk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_r        <= 3'd2;
      sb_r        <= 3'd2;
      ways_r      <= 4'd2;
      vld_r       <= '0;
      rkv_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BLOCK_BITS: if (geometry_ok(cfg_wdata[2:0], sb_r, ways_r)) begin
            bb_r <= cfg_wdata[2:0];
            vld_r <= '0;
            rkv_r <= '0;
          end
          REG_SET_BITS: if (geometry_ok(bb_r, cfg_wdata[2:0], ways_r)) begin
            sb_r <= cfg_wdata[2:0];
            vld_r <= '0;
            rkv_r <= '0;
          end
          REG_WAYS: if (geometry_ok(bb_r, sb_r, cfg_wdata)) begin
            ways_r <= cfg_wdata;
            vld_r <= '0;
            rkv_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.clr_step && !clr_r[ADDR_BITS]) clr_r <= clr_r + 1'b1;

      if (cmd.start || cmd.cnt_clr) begin
        cnt_r  <= '0;
        pend_r <= 1'b0;
      end else if (cmd.scan) begin
        pend_r <= (cnt_r < CNT_W'(ways_r));
        if (cnt_r < CNT_W'(ways_r)) cnt_r <= cnt_r + 1'b1;
      end else if (cmd.evict || cmd.fill) begin
        pend_r <= (cnt_r < bw);
        if (cnt_r < bw) cnt_r <= cnt_r + 1'b1;
      end else if (cmd.touch) begin
        if (cnt_r < CNT_W'(ways_r)) cnt_r <= cnt_r + 1'b1;
        if (rank_we) rkv_r[touch_line] <= 1'b1;
        if (meta_we) vld_r[ln] <= 1'b1;
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pidx_r <= cnt_r;
    if (cmd.start) begin
      addr_r      <= in_word.word_address;
      wr_r        <= in_word.is_write;
      data_r      <= in_word.store_word;
      tag_r       <= in_word.word_address >> (4'(bb_r) + 4'(sb_r));
      set_r       <= LINE_W'(in_set_w);
      base_r      <= LINE_W'(in_set_w[LINE_W-1:0] * ways_r);
      hit_r       <= 1'b0;
      best_set_r  <= 1'b0;
      best_r      <= '0;
      bway_r      <= '0;
      hway_r      <= '0;
      hrank_r     <= '0;
      hit_dirty_r <= 1'b0;
      vic_valid_r <= 1'b0;
      vic_dirty_r <= 1'b0;
      vic_tag_r   <= '0;
    end else if (cmd.scan && pend_r) begin
      rank_q_r[WAY_W'(pidx_r)] <= pr_rank;
      if (!hit_r && p_valid && (meta_rdata[ADDR_BITS-1:0] == tag_r)) begin
        hit_r       <= 1'b1;
        hway_r      <= WAY_W'(pidx_r);
        hrank_r     <= pr_rank;
        hit_dirty_r <= meta_rdata[ADDR_BITS];
      end
      if (!best_set_r || (pr_rank < best_r)) begin
        best_set_r  <= 1'b1;
        best_r      <= pr_rank;
        bway_r      <= WAY_W'(pidx_r);
        vic_valid_r <= p_valid;
        vic_dirty_r <= p_valid & meta_rdata[ADDR_BITS];
        vic_tag_r   <= meta_rdata[ADDR_BITS-1:0];
      end
    end
    if (cmd.capture) ld_r <= lw_rdata;
    if (cmd.emit) begin
      out_r.transfer_kind <= cmd.kind;
      out_r.last          <= (cmd.kind == KIND_LOAD) || (cmd.kind == KIND_STORE);
      out_r.load_word     <= (cmd.kind == KIND_LOAD) ? ld_r : 32'sd0;
      case (cmd.kind)
        KIND_WBACK, KIND_DROP: begin
          out_r.start_address <= vaddr;
          out_r.word_count    <= bw;
        end
        KIND_FILL: begin
          out_r.start_address <= block_base;
          out_r.word_count    <= bw;
        end
        default: begin
          out_r.start_address <= addr_r;
          out_r.word_count    <= 5'd1;
        end
      endcase
    end
  end

  assign st.clr_done  = clr_r[ADDR_BITS];
  assign st.way_done  = (cnt_r == CNT_W'(ways_r)) && !pend_r;
  assign st.blk_done  = (cnt_r == bw) && !pend_r;
  assign st.hit       = hit_r;
  assign st.vic_valid = vic_valid_r;
  assign st.vic_dirty = vic_dirty_r;
  assign st.is_write  = wr_r;
  assign st.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
